[hdl/node_address_text_parser_assert.svh]
// Assertion macros used by the address parser checker.
`ifndef NODE_ADDRESS_TEXT_PARSER_ASSERT_SVH
`define NODE_ADDRESS_TEXT_PARSER_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define NAP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("address parser check failed");

// Next-cycle implication, ignored while reset is high.
`define NAP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("address parser check failed");

// Next-cycle implication that is also checked across reset.
`define NAP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("address parser check failed");

`endif

[hdl/nap_pkg.sv]
// Types and constants of the node address text parser.
package nap_pkg;

  localparam int unsigned FIELD_WIDTH     = 16;
  localparam int unsigned NUM_FIELDS      = 4;
  localparam int unsigned CFG_INDEX_WIDTH = 3;

  // Field positions in the working field array.
  localparam logic [1:0] F_ZONE  = 2'd0;
  localparam logic [1:0] F_NET   = 2'd1;
  localparam logic [1:0] F_NODE  = 2'd2;
  localparam logic [1:0] F_POINT = 2'd3;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEFAULT_ZONE  = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEFAULT_NET   = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEFAULT_NODE  = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEFAULT_POINT = 3'd3;

  // Characters of the address syntax.
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;

  typedef logic [FIELD_WIDTH-1:0] field_t;
  typedef field_t [NUM_FIELDS-1:0] field_array_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic   parse_ok;
    field_t zone_out;
    field_t net_out;
    field_t node_out;
    field_t point_out;
  } out_item_t;

  typedef struct packed {
    logic         seen_zone_mark;
    logic         seen_net_mark;
    logic         seen_node_mark;
    logic         number_pending;
    field_t       digit_accumulator;
    field_array_t field_values;
    logic         failed;
    logic         string_started;
  } parse_state_t;

endpackage

[hdl/node_address_text_parser.sv]
// A word accepted into the input register is applied to the parser state when it leaves it,
// and the result of a last word is registered into out_data in that same update.
// Throughput: one word per cycle unless a held result stalls a last word, which then
// holds back later words too; the input register feeds the state combinationally.
// Synchronous reset clears the flags, the pipeline valids and the four templates to zero.
module node_address_text_parser (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  nap_pkg::in_item_t                      in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output nap_pkg::out_item_t                     out_data,
  input  logic                                   cfg_we,
  input  logic [nap_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [nap_pkg::FIELD_WIDTH-1:0]        cfg_data
);

  logic                  stage_valid;
  nap_pkg::in_item_t     stage_item;
  nap_pkg::parse_state_t state;
  nap_pkg::parse_state_t state_next;
  nap_pkg::field_array_t tmpl;
  nap_pkg::out_item_t    result;
  logic                  fire;

  // Only a last word needs room in the output register.
  assign fire     = stage_valid && (!stage_item.last || !out_valid || out_ready);
  assign in_ready = !stage_valid || fire;

  nap_step u_step (
    .state      (state),
    .tmpl       (tmpl),
    .item       (stage_item),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
      state       <= '0;
    end else begin
      if (in_ready) begin
        stage_valid <= in_valid;
      end
      if (fire) begin
        state <= state_next;
      end
      if (fire && stage_item.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_data;
    end
    if (fire && stage_item.last) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tmpl <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nap_pkg::CFG_DEFAULT_ZONE:  tmpl[nap_pkg::F_ZONE]  <= cfg_data;
        nap_pkg::CFG_DEFAULT_NET:   tmpl[nap_pkg::F_NET]   <= cfg_data;
        nap_pkg::CFG_DEFAULT_NODE:  tmpl[nap_pkg::F_NODE]  <= cfg_data;
        nap_pkg::CFG_DEFAULT_POINT: tmpl[nap_pkg::F_POINT] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

[hdl/nap_step.sv]
// Combinational per-byte update of the address parser state.
module nap_step (
  input  nap_pkg::parse_state_t state,
  input  nap_pkg::field_array_t tmpl,
  input  nap_pkg::in_item_t     item,
  output nap_pkg::parse_state_t state_next,
  output nap_pkg::out_item_t    result
);

  nap_pkg::parse_state_t s;
  logic [7:0]            digit;

  always_comb begin
    s = state;
    // The first word of a string starts from the template registers.
    if (!state.string_started) begin
      s                   = '0;
      s.field_values      = tmpl;
      s.string_started    = 1'b1;
    end
    digit = item.char_code - nap_pkg::CHAR_0;

    if (item.has_char && (item.char_code != nap_pkg::CHAR_NUL) && !s.failed) begin
      case (item.char_code) inside
        nap_pkg::CHAR_COLON: begin
          if (s.seen_zone_mark || s.seen_net_mark || s.seen_node_mark) begin
            s.failed = 1'b1;
          end else begin
            if (s.number_pending) begin
              s.field_values[nap_pkg::F_ZONE] = s.digit_accumulator;
            end
            s.seen_zone_mark = 1'b1;
            s.number_pending = 1'b0;
          end
        end
        nap_pkg::CHAR_SLASH: begin
          if (s.seen_net_mark || s.seen_node_mark) begin
            s.failed = 1'b1;
          end else begin
            if (s.number_pending) begin
              s.field_values[nap_pkg::F_NET] = s.digit_accumulator;
            end
            s.seen_net_mark  = 1'b1;
            s.number_pending = 1'b0;
          end
        end
        nap_pkg::CHAR_DOT: begin
          if (s.seen_node_mark) begin
            s.failed = 1'b1;
          end else begin
            if (s.number_pending) begin
              s.field_values[nap_pkg::F_NODE] = s.digit_accumulator;
            end
            s.seen_node_mark = 1'b1;
            s.number_pending = 1'b0;
          end
        end
        [nap_pkg::CHAR_0:nap_pkg::CHAR_9]: begin
          if (!s.number_pending) begin
            s.digit_accumulator = '0;
            s.number_pending    = 1'b1;
          end
          // Times ten as two shifts; the sum wraps at the field width.
          s.digit_accumulator = nap_pkg::FIELD_WIDTH'((s.digit_accumulator << 3)
                                + (s.digit_accumulator << 1)
                                + nap_pkg::FIELD_WIDTH'(digit));
        end
        default: begin
          s.failed = 1'b1;
        end
      endcase
    end

    result = '0;
    if (item.last) begin
      // A trailing number lands in net, point or node by the marks seen.
      if (!s.failed && s.number_pending) begin
        if (s.seen_zone_mark && !s.seen_net_mark) begin
          s.field_values[nap_pkg::F_NET] = s.digit_accumulator;
        end else if (s.seen_node_mark) begin
          s.field_values[nap_pkg::F_POINT] = s.digit_accumulator;
        end else begin
          s.field_values[nap_pkg::F_NODE] = s.digit_accumulator;
        end
      end
      result.parse_ok  = !s.failed;
      result.zone_out  = s.field_values[nap_pkg::F_ZONE];
      result.net_out   = s.field_values[nap_pkg::F_NET];
      result.node_out  = s.field_values[nap_pkg::F_NODE];
      result.point_out = s.field_values[nap_pkg::F_POINT];
      s.string_started = 1'b0;
    end

    state_next = s;
  end

endmodule

[hdl/nap_checker.sv]
// Port-level checks of the address parser and their binding to the top level.
`include "node_address_text_parser_assert.svh"

module nap_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input nap_pkg::out_item_t out_data
);

  `NAP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `NAP_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_data))
  `NAP_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid && in_ready)
  `NAP_ASSERT_IMP(a_ready_when_empty, clk, rst, !out_valid, in_ready)

endmodule

bind node_address_text_parser nap_checker u_nap_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[tb/tb_node_address_text_parser.sv]
// Self-checking testbench for the node address text parser.
`timescale 1ns / 1ps

module tb_node_address_text_parser;

  localparam int unsigned DECIMAL_BASE  = 10;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned PHASE_WORDS   = 620;
  localparam int unsigned HOLD_CYCLES   = 250;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  typedef nap_pkg::in_item_t item_q_t[$];

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  nap_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  nap_pkg::out_item_t out_data;
  logic                                cfg_we;
  logic [nap_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  nap_pkg::field_t                     cfg_data;

  // Predictor state and template copies.
  nap_pkg::parse_state_t prs;
  nap_pkg::field_t       template_regs [nap_pkg::NUM_FIELDS];

  nap_pkg::out_item_t pending_addresses[$];
  int unsigned  mismatch_count = 0;
  int unsigned  words_sent     = 0;
  int unsigned  cycle_count    = 0;
  int unsigned  send_idle_pct  = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  hold_request   = 0;
  int unsigned  hold_left      = 0;

  node_address_text_parser i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advances the parser by one word; returns 1 when the word closes a string.
  function automatic bit parse_word(input nap_pkg::in_item_t w,
                                    output nap_pkg::out_item_t res);
    int i;
    logic [7:0] c;
    res = '0;
    c = w.char_code;
    if (!prs.string_started) begin
      for (i = 0; i < nap_pkg::NUM_FIELDS; i++) prs.field_values[i] = template_regs[i];
      prs.seen_zone_mark    = 1'b0;
      prs.seen_net_mark     = 1'b0;
      prs.seen_node_mark    = 1'b0;
      prs.number_pending    = 1'b0;
      prs.digit_accumulator = '0;
      prs.failed            = 1'b0;
      prs.string_started    = 1'b1;
    end
    if (w.has_char && c != nap_pkg::CHAR_NUL && !prs.failed) begin
      case (c)
        nap_pkg::CHAR_COLON: begin
          if (prs.seen_zone_mark || prs.seen_net_mark || prs.seen_node_mark) begin
            prs.failed = 1'b1;
          end else begin
            if (prs.number_pending)
              prs.field_values[nap_pkg::F_ZONE] = prs.digit_accumulator;
            prs.seen_zone_mark = 1'b1;
            prs.number_pending = 1'b0;
          end
        end
        nap_pkg::CHAR_SLASH: begin
          if (prs.seen_net_mark || prs.seen_node_mark) begin
            prs.failed = 1'b1;
          end else begin
            if (prs.number_pending)
              prs.field_values[nap_pkg::F_NET] = prs.digit_accumulator;
            prs.seen_net_mark  = 1'b1;
            prs.number_pending = 1'b0;
          end
        end
        nap_pkg::CHAR_DOT: begin
          if (prs.seen_node_mark) begin
            prs.failed = 1'b1;
          end else begin
            if (prs.number_pending)
              prs.field_values[nap_pkg::F_NODE] = prs.digit_accumulator;
            prs.seen_node_mark = 1'b1;
            prs.number_pending = 1'b0;
          end
        end
        default: begin
          if (c >= nap_pkg::CHAR_0 && c <= nap_pkg::CHAR_9) begin
            if (!prs.number_pending) begin
              prs.digit_accumulator = '0;
              prs.number_pending    = 1'b1;
            end
            // The accumulator wraps at the field width.
            prs.digit_accumulator = nap_pkg::field_t'(
              prs.digit_accumulator * DECIMAL_BASE + (c - nap_pkg::CHAR_0));
          end else begin
            prs.failed = 1'b1;
          end
        end
      endcase
    end
    if (!w.last) return 1'b0;
    // A trailing number lands on net after a zone mark with no net mark, on point after a
    // node mark, and on node otherwise.
    if (!prs.failed && prs.number_pending) begin
      if (prs.seen_zone_mark && !prs.seen_net_mark)
        prs.field_values[nap_pkg::F_NET] = prs.digit_accumulator;
      else if (prs.seen_node_mark)
        prs.field_values[nap_pkg::F_POINT] = prs.digit_accumulator;
      else
        prs.field_values[nap_pkg::F_NODE] = prs.digit_accumulator;
    end
    res.parse_ok  = !prs.failed;
    res.zone_out  = prs.field_values[nap_pkg::F_ZONE];
    res.net_out   = prs.field_values[nap_pkg::F_NET];
    res.node_out  = prs.field_values[nap_pkg::F_NODE];
    res.point_out = prs.field_values[nap_pkg::F_POINT];
    prs.string_started = 1'b0;
    return 1'b1;
  endfunction

  function automatic nap_pkg::in_item_t char_word(input logic [7:0] c, input bit is_last);
    return nap_pkg::in_item_t'{char_code: c, has_char: 1'b1, last: is_last};
  endfunction

  // A word that adds no character: either has_char low or a zero byte.
  function automatic nap_pkg::in_item_t empty_word(input bit is_last);
    nap_pkg::in_item_t w;
    if ($urandom_range(1) == 0)
      w = nap_pkg::in_item_t'{char_code: 8'($urandom_range(255)), has_char: 1'b0,
                              last: is_last};
    else
      w = nap_pkg::in_item_t'{char_code: nap_pkg::CHAR_NUL, has_char: 1'b1, last: is_last};
    return w;
  endfunction

  function automatic item_q_t text_words(input string s, input bit end_marker,
                                         input int unsigned filler_pct);
    item_q_t q;
    int i;
    for (i = 0; i < s.len(); i++) begin
      if ($urandom_range(99) < filler_pct) q.push_back(empty_word(1'b0));
      q.push_back(char_word(s[i], !end_marker && i == s.len() - 1));
    end
    if (end_marker || s.len() == 0) q.push_back(empty_word(1'b1));
    return q;
  endfunction

  function automatic string number_text();
    int unsigned r;
    int unsigned bound;
    r = $urandom_range(99);
    if (r < 10) return "";
    if (r < 40)      bound = 9;
    else if (r < 70) bound = 999;
    else if (r < 90) bound = 65535;
    else             bound = 99999;
    return $sformatf("%0d", $urandom_range(bound));
  endfunction

  function automatic item_q_t address_words();
    string s;
    s = "";
    if ($urandom_range(99) < 40) s = {s, number_text(), ":"};
    if ($urandom_range(99) < 60) s = {s, number_text(), "/"};
    s = {s, number_text()};
    if ($urandom_range(99) < 40) s = {s, ".", number_text()};
    return text_words(s, $urandom_range(99) < 15, 5);
  endfunction

  // Broken strings: digits, delimiters and arbitrary bytes in random order.
  function automatic item_q_t noise_words();
    item_q_t q;
    int n;
    int i;
    int unsigned r;
    logic [7:0] c;
    n = $urandom_range(8, 1);
    for (i = 0; i < n; i++) begin
      r = $urandom_range(9);
      if (r < 4)      c = nap_pkg::CHAR_0 + 8'($urandom_range(9));
      else if (r < 5) c = nap_pkg::CHAR_COLON;
      else if (r < 6) c = nap_pkg::CHAR_SLASH;
      else if (r < 7) c = nap_pkg::CHAR_DOT;
      else            c = 8'($urandom_range(255));
      q.push_back(nap_pkg::in_item_t'{char_code: c, has_char: ($urandom_range(9) != 0),
                                      last: (i == n - 1)});
    end
    return q;
  endfunction

  task automatic send_word(input nap_pkg::in_item_t w);
    nap_pkg::out_item_t res;
    int unsigned        gap;
    // Each cycle the sender stays idle with the phase's idle chance.
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    if (parse_word(w, res)) pending_addresses.push_back(res);
    words_sent++;
  endtask

  task automatic send_items(input item_q_t q);
    foreach (q[i]) send_word(q[i]);
  endtask

  task automatic write_template(input logic [nap_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                input nap_pkg::field_t value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx < nap_pkg::NUM_FIELDS) template_regs[idx] = value;
  endtask

  task automatic load_templates(input nap_pkg::field_t value, input bit scramble);
    int i;
    for (i = 0; i < nap_pkg::NUM_FIELDS; i++)
      write_template(nap_pkg::CFG_INDEX_WIDTH'(i),
                     scramble ? nap_pkg::field_t'($urandom_range(65535)) : value);
  endtask

  // Waits until every expected address has come out and the pipeline is quiet.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_addresses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_templates();
    int idx;
    write_template(nap_pkg::CFG_DEFAULT_ZONE, '1);
    write_template(nap_pkg::CFG_DEFAULT_NET, '0);
    write_template(nap_pkg::CFG_DEFAULT_NODE, nap_pkg::field_t'($urandom_range(65535)));
    write_template(nap_pkg::CFG_DEFAULT_POINT, nap_pkg::field_t'(1));
    // Indexes past the last register must leave the templates alone.
    for (idx = nap_pkg::NUM_FIELDS; idx < 2 ** nap_pkg::CFG_INDEX_WIDTH; idx++)
      write_template(nap_pkg::CFG_INDEX_WIDTH'(idx),
                     nap_pkg::field_t'($urandom_range(65535)));
    send_items(text_words("", 1'b1, 0));
    drain();
  endtask

  task automatic test_syntax();
    item_q_t q;
    send_items(text_words("1:2/3.4", 1'b0, 0));
    send_items(text_words("70000", 1'b0, 0));
    send_items(text_words("1:2", 1'b0, 0));
    send_items(text_words("1::", 1'b0, 0));
    send_word(char_word(8'hFF, 1'b1));
    // Characters that must be skipped: a colon without has_char and a zero byte.
    q = {char_word(nap_pkg::CHAR_0 + 8'd5, 1'b0),
         nap_pkg::in_item_t'{char_code: nap_pkg::CHAR_COLON, has_char: 1'b0, last: 1'b0},
         char_word(nap_pkg::CHAR_NUL, 1'b0), char_word(nap_pkg::CHAR_SLASH, 1'b0),
         char_word(nap_pkg::CHAR_0 + 8'd7, 1'b1)};
    send_items(q);
    drain();
  endtask

  // Templates are taken at the first word of a string; a later write only
  // affects the next string.
  task automatic test_template_sampling();
    load_templates('0, 1'b1);
    send_word(char_word(nap_pkg::CHAR_0 + 8'd5, 1'b0));
    drain();
    load_templates('0, 1'b0);
    send_items(text_words(".7", 1'b0, 0));
    send_items(text_words("", 1'b1, 0));
    drain();
  endtask

  task automatic run_random_phase(input int unsigned send_pct, input int unsigned recv_pct);
    int unsigned start;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    start = words_sent;
    while (words_sent - start < PHASE_WORDS) begin
      if ($urandom_range(99) < 80) send_items(address_words());
      else                         send_items(noise_words());
    end
    drain();
  endtask

  task automatic test_random_streams();
    load_templates('1, 1'b0);
    run_random_phase(20, 47);
    load_templates('0, 1'b1);
    run_random_phase(47, 20);
    load_templates('0, 1'b0);
    run_random_phase(0, 0);
  endtask

  // The receiver stops for a long stretch while single-digit strings keep coming.
  task automatic test_backpressure();
    int i;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = HOLD_CYCLES;
    for (i = 0; i < 48; i++)
      send_items(text_words($sformatf("%0d", $urandom_range(9)), 1'b0, 0));
    drain();
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    prs       = '0;
    foreach (template_regs[i]) template_regs[i] = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    test_templates();
    test_syntax();
    test_template_sampling();
    test_random_streams();
    test_backpressure();
    if (mismatch_count == 0)
      $display("tb_node_address_text_parser: done, clean");
    else
      $display("tb_node_address_text_parser: done, errors");
    $finish;
  end

  always @(negedge clk) begin : drive_ready
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input nap_pkg::field_t want,
                             input nap_pkg::field_t got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    nap_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_addresses.size() == 0) begin
        $error("address result with none expected");
        mismatch_count++;
      end else begin
        want = pending_addresses.pop_front();
        check_field("parse_ok", nap_pkg::field_t'(want.parse_ok),
                    nap_pkg::field_t'(out_data.parse_ok));
        check_field("zone_out", want.zone_out, out_data.zone_out);
        check_field("net_out", want.net_out, out_data.net_out);
        check_field("node_out", want.node_out, out_data.node_out);
        check_field("point_out", want.point_out, out_data.point_out);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_node_address_text_parser: done, errors");
      $finish;
    end
  end

endmodule
